### rtl/core/accel_shake_event_detector_defines.svh
// Assertion macros used by the port-level checker of the shake event detector.
// Depends on nothing; the including module must have signals named clock and reset.
`ifndef ACCEL_SHAKE_EVENT_DETECTOR_DEFINES_SVH
`define ACCEL_SHAKE_EVENT_DETECTOR_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define ASED_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ASED_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASED_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ased_pkg.sv
// Package of the shake event detector: payload structs, register indexes and constants.
// Depends on nothing; used by every module of the block.
`default_nettype none

package ased_pkg;

   // Fixed-point format of the acceleration axes.
   localparam int FRAC_BITS  = 12;
   localparam int FILT_SHIFT = 8;
   localparam int FILT_W     = (FRAC_BITS + FILT_SHIFT + 1 > 24) ?
                               (FRAC_BITS + FILT_SHIFT + 1) : 24;
   localparam logic [FILT_W-1:0] ONE_G_FILT = FILT_W'(1) << (FRAC_BITS + FILT_SHIFT);

   // Division by ten as a multiply by the rounded-up reciprocal and a shift.
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int          DIV_SHIFT = 35;

   localparam int AXIS_W   = 16;
   localparam int MAG_W    = 16;
   localparam int THRESH_W = 15;
   localparam int MS_W     = 16;
   localparam int RUNS_W   = 8;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEV_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_RUN_MS    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RUN_MS    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE_MS   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_RUNS      = 3'd4;

   localparam logic [THRESH_W-1:0] RST_DEV_THRESHOLD = 15'd2048;
   localparam logic [MS_W-1:0]     RST_MIN_RUN_MS    = 16'd100;
   localparam logic [MS_W-1:0]     RST_MAX_RUN_MS    = 16'd2000;
   localparam logic [MS_W-1:0]     RST_DEBOUNCE_MS   = 16'd500;
   localparam logic [RUNS_W-1:0]   RST_MIN_RUNS      = 8'd2;
   localparam logic [RUNS_W-1:0]   RUNS_MAX          = 8'd255;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic [TIME_W-1:0]        time_ms;
   } req_payload_type;

   typedef struct packed {
      logic               shake_event;
      logic               in_motion;
      logic               bad_duration;
      logic [RUNS_W-1:0]  run_count;
      logic [COUNT_W-1:0] event_count;
   } rsp_payload_type;

   // Status from the magnitude unit back to the sequencer.
   typedef struct packed {
      logic done;
      logic moves;
   } mag_status_type;

endpackage

`default_nettype wire

### rtl/core/accel_shake_event_detector.sv
// Shake event detector top level: handshakes, configuration registers, run tracking.
// Depends on ased_pkg and ased_mag_unit.
`default_nettype none

// The block takes one transfer per accelerometer sample and returns exactly one result
// transfer for it. A sample (mode 0) is squared axis by axis on one shared multiplier,
// its magnitude is found by a bit-serial integer square root that resolves one result
// bit per cycle, and the magnitude then feeds a first-order low-pass filter whose
// divide by ten reuses the same multiplier. The filtered value decides whether the
// sample is in motion, and the end of a motion run is checked against the minimum and
// maximum run length, the debounce interval and the run count. No new input transfer
// is taken until the result of the current one has been written; for a sample most of
// that time goes to the square-root loop, while a clear request (mode 1) only resets
// the event count. req_ready is low while an item is being worked on. The result sits
// in an output register, so a new input transfer is taken while the previous result
// still waits for rsp_ready; the new result is only written once that register is
// free. Configuration writes through csr_we take effect at once and are meant to be
// made while no item is in flight; there is no read-back.
module accel_shake_event_detector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_ready,
   input  wire ased_pkg::req_payload_type          req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   output      ased_pkg::rsp_payload_type          rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [ased_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [ased_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } top_state_type;

   top_state_type                         state_ff, state_in;

   // Configuration registers.
   logic [ased_pkg::THRESH_W-1:0]         thresh_ff;
   logic [ased_pkg::MS_W-1:0]             min_run_ff;
   logic [ased_pkg::MS_W-1:0]             max_run_ff;
   logic [ased_pkg::MS_W-1:0]             debounce_ff;
   logic [ased_pkg::RUNS_W-1:0]           min_runs_ff;

   // Run tracking state.
   logic                                  active_ff, active_in;
   logic [ased_pkg::TIME_W-1:0]           run_start_ff, run_start_in;
   logic [ased_pkg::TIME_W-1:0]           last_event_ff, last_event_in;
   logic [ased_pkg::RUNS_W-1:0]           runs_ff, runs_in;
   logic [ased_pkg::COUNT_W-1:0]          events_ff, events_in;

   // Current item.
   logic                                  mode_ff, mode_in;
   logic [ased_pkg::TIME_W-1:0]           time_ff, time_in;
   logic                                  moves_ff, moves_in;

   // Output register.
   logic                                  rsp_valid_ff, rsp_valid_in;
   ased_pkg::rsp_payload_type             rsp_data_ff, rsp_data_in;

   logic                                  req_fire;
   logic                                  unit_start;
   logic                                  commit;
   logic                                  shake, bad;
   logic [ased_pkg::TIME_W-1:0]           dur, since;
   ased_pkg::mag_status_type              mag_status;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign unit_start = req_fire && (req_data.mode == ased_pkg::MODE_SAMPLE);
   // The result is written once the output register is empty or being emptied.
   assign commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   ased_mag_unit u_mag (
      .clock     (clock),
      .reset     (reset),
      .start     (unit_start),
      .sample    (req_data),
      .threshold (thresh_ff),
      .status    (mag_status)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      time_in  = time_ff;
      moves_in = moves_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_data.mode;
               time_in  = req_data.time_ms;
               moves_in = 1'b0;
               state_in = (req_data.mode == ased_pkg::MODE_CLEAR) ? ST_DONE : ST_CALC;
            end
         end
         ST_CALC: begin
            if (mag_status.done) begin
               moves_in = mag_status.moves;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Both time differences wrap at 32 bits.
   assign dur   = time_ff - run_start_ff;
   assign since = time_ff - last_event_ff;

   // Motion run tracking. A run starts on the first moving sample and ends on the
   // first quiet one; only the end of a run can produce an event or a bad duration.
   always_comb begin
      active_in     = active_ff;
      run_start_in  = run_start_ff;
      last_event_in = last_event_ff;
      runs_in       = runs_ff;
      events_in     = events_ff;
      shake         = 1'b0;
      bad           = 1'b0;
      if (mode_ff == ased_pkg::MODE_CLEAR) begin
         events_in = '0;
      end else if (moves_ff) begin
         if (!active_ff) begin
            active_in    = 1'b1;
            run_start_in = time_ff;
            if (runs_ff != ased_pkg::RUNS_MAX) begin
               runs_in = runs_ff + ased_pkg::RUNS_W'(1);
            end
         end
      end else if (active_ff) begin
         active_in = 1'b0;
         if ((dur >= ased_pkg::TIME_W'(min_run_ff)) && (dur <= ased_pkg::TIME_W'(max_run_ff))) begin
            // A good run inside the debounce interval leaves the run count alone.
            if (since >= ased_pkg::TIME_W'(debounce_ff)) begin
               if (runs_ff >= min_runs_ff) begin
                  shake         = 1'b1;
                  events_in     = events_ff + ased_pkg::COUNT_W'(1);
                  last_event_in = time_ff;
               end
               runs_in = '0;
            end
         end else begin
            bad = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.shake_event  = shake;
         rsp_data_in.in_motion    = active_in;
         rsp_data_in.bad_duration = bad;
         rsp_data_in.run_count    = runs_in;
         rsp_data_in.event_count  = events_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         run_start_ff  <= '0;
         last_event_ff <= '0;
         runs_ff       <= '0;
         events_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            active_ff     <= active_in;
            run_start_ff  <= run_start_in;
            last_event_ff <= last_event_in;
            runs_ff       <= runs_in;
            events_ff     <= events_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      time_ff     <= time_in;
      moves_ff    <= moves_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers; writes to unused indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff   <= ased_pkg::RST_DEV_THRESHOLD;
         min_run_ff  <= ased_pkg::RST_MIN_RUN_MS;
         max_run_ff  <= ased_pkg::RST_MAX_RUN_MS;
         debounce_ff <= ased_pkg::RST_DEBOUNCE_MS;
         min_runs_ff <= ased_pkg::RST_MIN_RUNS;
      end else if (csr_we) begin
         case (csr_addr)
            ased_pkg::CSR_DEV_THRESHOLD: begin
               thresh_ff <= csr_wdata[ased_pkg::THRESH_W-1:0];
            end
            ased_pkg::CSR_MIN_RUN_MS: begin
               min_run_ff <= csr_wdata[ased_pkg::MS_W-1:0];
            end
            ased_pkg::CSR_MAX_RUN_MS: begin
               max_run_ff <= csr_wdata[ased_pkg::MS_W-1:0];
            end
            ased_pkg::CSR_DEBOUNCE_MS: begin
               debounce_ff <= csr_wdata[ased_pkg::MS_W-1:0];
            end
            ased_pkg::CSR_MIN_RUNS: begin
               min_runs_ff <= csr_wdata[ased_pkg::RUNS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/core/ased_mag_unit.sv
// Magnitude and low-pass filter unit: squares, bit-serial square root, filter, motion test.
// Depends on ased_pkg.
`default_nettype none

module ased_mag_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire ased_pkg::req_payload_type       sample,
   input  wire logic [ased_pkg::THRESH_W-1:0]   threshold,
   output ased_pkg::mag_status_type             status
);

   typedef enum logic [6:0] {
      U_IDLE = 7'b000_0001,
      U_SQR  = 7'b000_0010,
      U_ROOT = 7'b000_0100,
      U_SUM  = 7'b000_1000,
      U_DIV  = 7'b001_0000,
      U_FILT = 7'b010_0000,
      U_DEV  = 7'b100_0000
   } unit_state_type;

   localparam int ABS_W = ased_pkg::AXIS_W + 1;

   function automatic logic [ABS_W-1:0] abs_axis(input logic signed [ased_pkg::AXIS_W-1:0] a);
      logic [ABS_W-1:0] ext;
      ext = {a[ased_pkg::AXIS_W-1], a};
      return ext[ABS_W-1] ? (~ext + ABS_W'(1)) : ext;
   endfunction

   unit_state_type                  state_ff, state_in;
   logic [1:0]                      cnt_ff, cnt_in;
   logic [ased_pkg::FILT_W-1:0]     filt_ff, filt_in;
   logic [ABS_W-1:0]                abs_ff [3];
   logic [ABS_W-1:0]                abs_in [3];
   logic [31:0]                     v_ff, v_in;
   logic [31:0]                     res_ff, res_in;
   logic [31:0]                     bit_ff, bit_in;
   logic [31:0]                     num_ff, num_in;
   logic [63:0]                     prod_ff, prod_in;

   logic [31:0]                     mul_a, mul_b;
   logic [63:0]                     mul_p;
   logic [32:0]                     trial;
   logic                            fits;
   logic [ased_pkg::FILT_W-1:0]     dev;

   // Shared multiplier: squares the axes, then divides the filter sum by ten.
   always_comb begin
      if (state_ff == U_SQR) begin
         mul_a = 32'(abs_ff[0]);
         mul_b = 32'(abs_ff[0]);
      end else begin
         mul_a = num_ff;
         mul_b = ased_pkg::RECIP_TEN;
      end
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits  = {1'b0, v_ff} >= trial;
   assign dev   = (filt_ff >= ased_pkg::ONE_G_FILT) ? (filt_ff - ased_pkg::ONE_G_FILT)
                                                    : (ased_pkg::ONE_G_FILT - filt_ff);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      filt_in  = filt_ff;
      abs_in   = abs_ff;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      status   = '0;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               abs_in[0] = abs_axis(sample.accel_x);
               abs_in[1] = abs_axis(sample.accel_y);
               abs_in[2] = abs_axis(sample.accel_z);
               cnt_in    = 2'd0;
               v_in      = '0;
               state_in  = U_SQR;
            end
         end
         U_SQR: begin
            // One square per cycle; the previous square is registered and added in the next cycle.
            prod_in   = mul_p;
            abs_in[0] = abs_ff[1];
            abs_in[1] = abs_ff[2];
            abs_in[2] = '0;
            if (cnt_ff != 2'd0) begin
               v_in = v_ff + prod_ff[31:0];
            end
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               res_in   = '0;
               bit_in   = 32'h4000_0000;
               state_in = U_ROOT;
            end
         end
         U_ROOT: begin
            if (fits) begin
               v_in   = v_ff - trial[31:0];
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = U_SUM;
            end
         end
         U_SUM: begin
            num_in = (32'(res_ff[ased_pkg::MAG_W-1:0]) << ased_pkg::FILT_SHIFT)
                   + (32'(filt_ff) << 3) + 32'(filt_ff) + 32'd5;
            state_in = U_DIV;
         end
         U_DIV: begin
            prod_in  = mul_p;
            state_in = U_FILT;
         end
         U_FILT: begin
            filt_in  = prod_ff[ased_pkg::DIV_SHIFT +: ased_pkg::FILT_W];
            state_in = U_DEV;
         end
         U_DEV: begin
            status.done  = 1'b1;
            status.moves = dev > ased_pkg::FILT_W'({threshold, ased_pkg::FILT_SHIFT'(0)});
            state_in     = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         filt_ff  <= ased_pkg::ONE_G_FILT;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         filt_ff  <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_ff  <= abs_in;
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      num_ff  <= num_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### rtl/core/ased_checker.sv
// Port-level checker for the shake event detector, bound to the top level.
// Depends on ased_pkg and accel_shake_event_detector_defines.svh.
`default_nettype none
`include "accel_shake_event_detector_defines.svh"

module ased_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire ased_pkg::rsp_payload_type  rsp_data
);

   `ASED_ASSERT_ALWAYS(a_reset_empties_output, reset, !rsp_valid, "result valid after reset")

   `ASED_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready while busy")

   `ASED_ASSERT_NEXT(a_result_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   `ASED_ASSERT_NOW(a_event_ends_run, rsp_valid && rsp_data.shake_event, !rsp_data.in_motion && !rsp_data.bad_duration, "event with motion or bad run")

   `ASED_ASSERT_NOW(a_bad_ends_run, rsp_valid && rsp_data.bad_duration, !rsp_data.in_motion, "bad run while in motion")

endmodule

bind accel_shake_event_detector ased_checker u_ased_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### sim/ased_shake_checker.sv
`timescale 1ns / 1ps
// Checker for the shake event detector: mirrors its registers, predicts each result, compares.
// Depends on ased_pkg; instantiated next to the block by tb_top.
module ased_shake_checker
   import ased_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_payload_type       req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_payload_type       rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   // Register mirror.
   logic [THRESH_W-1:0] thresh;
   logic [MS_W-1:0]     min_run;
   logic [MS_W-1:0]     max_run;
   logic [MS_W-1:0]     debounce;
   logic [RUNS_W-1:0]   min_runs;

   // Detector state.
   logic [FILT_W-1:0]   filt_mag;
   logic                motion_on;
   logic [TIME_W-1:0]   run_start;
   logic [TIME_W-1:0]   last_event;
   logic [RUNS_W-1:0]   runs_seen;
   logic [COUNT_W-1:0]  events_total;

   rsp_payload_type     due_results[$];

   function automatic logic [MAG_W-1:0] floor_sqrt(input logic [35:0] v);
      logic [35:0] rem;
      logic [35:0] root;
      logic [35:0] bit_w;
      rem   = v;
      root  = '0;
      bit_w = 36'd1 << 34;
      while (bit_w > rem)
         bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= root + bit_w) begin
            rem  = rem - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root[MAG_W-1:0];
   endfunction

   // Advances the detector state by one sample and returns the result it produces.
   function automatic rsp_payload_type track_shake(input req_payload_type s);
      rsp_payload_type   r;
      longint            sx;
      longint            sy;
      longint            sz;
      longint unsigned   sq;
      longint unsigned   acc;
      longint unsigned   dev;
      logic [MAG_W-1:0]  mag;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] since_event;
      r = '0;
      if (s.mode == MODE_CLEAR) begin
         events_total = '0;
      end else begin
         sx  = $signed(s.accel_x);
         sy  = $signed(s.accel_y);
         sz  = $signed(s.accel_z);
         sq  = sx * sx + sy * sy + sz * sz;
         mag = floor_sqrt(sq[35:0]);
         acc = (64'(mag) << FILT_SHIFT) + 64'd9 * 64'(filt_mag) + 64'd5;
         filt_mag = FILT_W'(acc / 64'd10);
         dev = (filt_mag >= ONE_G_FILT) ? 64'(filt_mag - ONE_G_FILT)
                                        : 64'(ONE_G_FILT - filt_mag);
         if (dev > (64'(thresh) << FILT_SHIFT)) begin
            if (!motion_on) begin
               motion_on = 1'b1;
               run_start = s.time_ms;
               if (runs_seen != RUNS_MAX)
                  runs_seen = runs_seen + 1'b1;
            end
         end else if (motion_on) begin
            motion_on   = 1'b0;
            span        = s.time_ms - run_start;
            since_event = s.time_ms - last_event;
            if (span >= TIME_W'(min_run) && span <= TIME_W'(max_run)) begin
               if (since_event >= TIME_W'(debounce)) begin
                  if (runs_seen >= min_runs) begin
                     r.shake_event = 1'b1;
                     events_total  = events_total + 1'b1;
                     last_event    = s.time_ms;
                  end
                  runs_seen = '0;
               end
            end else begin
               r.bad_duration = 1'b1;
            end
         end
      end
      r.in_motion   = motion_on;
      r.run_count   = runs_seen;
      r.event_count = events_total;
      return r;
   endfunction

   function automatic string show(input rsp_payload_type r);
      return $sformatf("event=%0b motion=%0b bad=%0b runs=%0d count=%0d",
                       r.shake_event, r.in_motion, r.bad_duration, r.run_count, r.event_count);
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         thresh       = RST_DEV_THRESHOLD;
         min_run      = RST_MIN_RUN_MS;
         max_run      = RST_MAX_RUN_MS;
         debounce     = RST_DEBOUNCE_MS;
         min_runs     = RST_MIN_RUNS;
         filt_mag     = ONE_G_FILT;
         motion_on    = 1'b0;
         run_start    = '0;
         last_event   = '0;
         runs_seen    = '0;
         events_total = '0;
         mismatches   = 0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEV_THRESHOLD: thresh   = csr_wdata[THRESH_W-1:0];
               CSR_MIN_RUN_MS:    min_run  = csr_wdata[MS_W-1:0];
               CSR_MAX_RUN_MS:    max_run  = csr_wdata[MS_W-1:0];
               CSR_DEBOUNCE_MS:   debounce = csr_wdata[MS_W-1:0];
               CSR_MIN_RUNS:      min_runs = csr_wdata[RUNS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            due_results.push_back(track_shake(req_data));
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with nothing outstanding: %s", $realtime, show(rsp_data));
               mismatches++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.shake_event !== want.shake_event ||
                   rsp_data.in_motion !== want.in_motion ||
                   rsp_data.bad_duration !== want.bad_duration ||
                   rsp_data.run_count !== want.run_count ||
                   rsp_data.event_count !== want.event_count) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected %s, got %s", $realtime, show(want),
                              show(rsp_data));
                  mismatches++;
               end
            end
         end
      end
      outstanding = due_results.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Top of the shake event detector testbench: clock, reset, stimulus, receiver and verdict.
// Depends on ased_pkg, accel_shake_event_detector and ased_shake_checker.
module tb_top;
   import ased_pkg::*;

   // A stalled receiver holds off this long so the block fills and blocks its input.
   localparam int HOLD_OFF_CYCLES = 300;
   // Cycles without any transfer or register write before the run is declared hung.
   localparam int WATCHDOG_LIMIT  = 5000;
   // Quiet time after the last result before registers change or the run ends.
   localparam int SETTLE_CYCLES   = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_data;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;

   // Transfers seen at the last rising edge, read by the stimulus at the falling edge.
   logic req_taken    = 1'b0;
   int   quiet_cycles = 0;

   int   req_idle_pct;
   int   rsp_idle_pct;
   logic hold_off_request;
   // Millisecond clock of the simulated sensor; it starts anywhere and wraps freely.
   logic [TIME_W-1:0] now_ms;
   // Threshold currently programmed, used to size the motion bursts.
   int unsigned cur_thr;

   accel_shake_event_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   ased_shake_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The stimulus drives at the falling edge, so it learns about an input transfer
   // through this flag, registered at the rising edge where the transfer happened.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // Watchdog: any transfer or register write restarts the count. A hung block, or a
   // result that never shows up while the stimulus waits for it, ends the run here.
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver. It stalls at random with the current idle rate. When the stimulus asks
   // for a hold-off, it keeps ready low for a long stretch that it counts on its own,
   // while the sender keeps offering samples.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               rsp_ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_ready <= (int'($urandom_range(99)) >= rsp_idle_pct);
      end
   end

   function automatic req_payload_type make_sample(input logic mode, input int x, input int y,
                                                   input int z, input logic [TIME_W-1:0] t);
      req_payload_type s;
      s.mode    = mode;
      s.accel_x = AXIS_W'(x);
      s.accel_y = AXIS_W'(y);
      s.accel_z = AXIS_W'(z);
      s.time_ms = t;
      return s;
   endfunction

   // A sample whose magnitude is carried by one axis of random choice and sign, with
   // a little noise on the other two.
   function automatic req_payload_type along_axis(input int unsigned mag,
                                                  input int unsigned jitter,
                                                  input logic [TIME_W-1:0] t);
      int v[3];
      int k;
      for (k = 0; k < 3; k++)
         v[k] = int'($urandom_range(2 * jitter)) - int'(jitter);
      k = $urandom_range(2);
      if (mag > 32767)
         mag = 32767;
      v[k] = $urandom_range(1) ? int'(mag) : -int'(mag);
      return make_sample(MODE_SAMPLE, v[0], v[1], v[2], t);
   endfunction

   // Every field random, the mode included: this is what exercises all the bits.
   function automatic req_payload_type wild_sample();
      return make_sample(logic'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
   endfunction

   // Sensor time moves on by a usual sample period, now and then by a long gap.
   function automatic void advance_clock(input int unsigned step_max);
      if ($urandom_range(49) == 0)
         now_ms = now_ms + $urandom_range(5000);
      else
         now_ms = now_ms + $urandom_range(step_max);
   endfunction

   // One input transfer. An idle gap of random length may come first; valid then
   // stays high with the payload steady until the transfer is seen. The caller's next
   // action, at the same falling edge, either offers a new sample or drops valid.
   task automatic send_item(input req_payload_type s);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(negedge clock); while (!req_taken);
   endtask

   // Stops offering samples and waits until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [CSR_DATA_W-1:0] thr,
                               input logic [CSR_DATA_W-1:0] min_ms,
                               input logic [CSR_DATA_W-1:0] max_ms,
                               input logic [CSR_DATA_W-1:0] gap_ms,
                               input logic [CSR_DATA_W-1:0] runs);
      write_reg(CSR_DEV_THRESHOLD, thr);
      write_reg(CSR_MIN_RUN_MS, min_ms);
      write_reg(CSR_MAX_RUN_MS, max_ms);
      write_reg(CSR_DEBOUNCE_MS, gap_ms);
      write_reg(CSR_MIN_RUNS, runs);
      cur_thr = thr[THRESH_W-1:0];
   endtask

   // Gesture-like traffic: a short burst of strong or near-zero acceleration, then a
   // stretch of rest at about 1 g so the filtered magnitude settles and the run ends.
   // A few wild samples, clear requests and clock jumps are mixed in.
   task automatic play_gestures(input int count, input int unsigned step_max);
      req_payload_type s;
      int              sent;
      int              pick;
      int              len;
      int              i;
      int unsigned     lift;
      logic            falling;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_item(wild_sample());
            sent++;
         end else if (pick < 8) begin
            s      = wild_sample();
            s.mode = MODE_CLEAR;
            send_item(s);
            sent++;
         end else if (pick < 10) begin
            now_ms = now_ms + $urandom;
         end else begin
            len     = $urandom_range(1, 6);
            lift    = cur_thr * $urandom_range(2, 10) + $urandom_range(256, 2048);
            falling = ($urandom_range(4) == 0);
            for (i = 0; i < len && sent < count; i++) begin
               advance_clock(step_max);
               if (falling)
                  s = along_axis($urandom_range(1024), 200, now_ms);
               else if ($urandom_range(9) == 0)
                  s = make_sample(MODE_SAMPLE, $urandom, $urandom, $urandom, now_ms);
               else
                  s = along_axis(4096 + lift, 300, now_ms);
               send_item(s);
               sent++;
            end
            len = $urandom_range(1, 25);
            for (i = 0; i < len && sent < count; i++) begin
               advance_clock(step_max);
               send_item(along_axis($urandom_range(4060, 4130), 48, now_ms));
               sent++;
            end
         end
      end
   endtask

   // Alternating 3 g and 1 g samples. With a threshold of 1 g the filtered magnitude
   // settles into a swing across the threshold, so every pair opens and closes a run.
   // That is the quickest way to fill the run counter.
   task automatic play_run_ladder(input int pairs);
      int i;
      for (i = 0; i < pairs; i++) begin
         now_ms = now_ms + 20;
         send_item(along_axis(12288, 0, now_ms));
         now_ms = now_ms + 20;
         send_item(along_axis(4096, 0, now_ms));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      hold_off_request = 1'b0;
      req_idle_pct     = 38;
      rsp_idle_pct     = 69;
      now_ms           = $urandom;
      cur_thr          = RST_DEV_THRESHOLD;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, under the reset register values. A clear request with all of
      // its ignored fields at extremes, then a run that starts on full-scale axes,
      // goes on through continued motion and ends while free fall pulls the filter
      // back: too few runs have been seen, so nothing is reported.
      send_item(make_sample(MODE_CLEAR, -32768, 32767, -1, 32'hFFFF_FFFF));
      send_item(make_sample(MODE_SAMPLE, -32768, -32768, -32768, 32'd1000));
      send_item(make_sample(MODE_SAMPLE, 32767, 32767, 32767, 32'd1020));
      send_item(make_sample(MODE_SAMPLE, -32768, 0, 0, 32'd1040));
      for (int i = 0; i < 10; i++)
         send_item(make_sample(MODE_SAMPLE, 0, 0, 0, 32'd1060 + 20 * i));
      send_item(make_sample(MODE_CLEAR, 0, 0, 0, 32'd0));
      send_item(make_sample(MODE_SAMPLE, 0, 0, 4096, 32'd0));
      send_item(make_sample(MODE_SAMPLE, 32767, -32768, 1, 32'h8000_0000));
      send_item(make_sample(MODE_SAMPLE, 0, 0, -4096, 32'hFFFF_FFFF));
      send_item(make_sample(MODE_SAMPLE, 4096, 0, 0, 32'h0000_0010));
      drain_results();

      // Sender idles now and then, receiver mostly stalls. Reset register values
      // first, then a permissive setting where every valid run reports an event.
      play_gestures(300, 40);
      drain_results();
      program_regs(16'd512, 16'd0, 16'hFFFF, 16'd0, 16'd0);
      play_gestures(150, 40);
      hold_off_request = 1'b1;
      play_gestures(150, 40);
      drain_results();

      // Rates swapped. Inverted run bounds make every run bad, so nothing clears the
      // run counter and the ladder drives it into saturation. Halfway through, the
      // sender pauses until every result is back.
      req_idle_pct = 69;
      rsp_idle_pct = 38;
      program_regs(16'd4096, 16'hFFFF, 16'd0, 16'hFFFF, 16'd255);
      play_run_ladder(140);
      drain_results();
      play_run_ladder(140);
      drain_results();
      program_regs($urandom_range(0, 4096), $urandom_range(0, 200), $urandom_range(100, 3000),
                   $urandom_range(0, 1000), $urandom_range(0, 4));
      play_gestures(300, $urandom_range(5, 80));
      drain_results();

      // No idling at all. Zero threshold and a zero-length valid window with short
      // sample periods, then the largest threshold (written with its unused top bit
      // set) with the other registers back at their reset values.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      play_gestures(250, 2);
      drain_results();
      program_regs(16'hFFFF, RST_MIN_RUN_MS, RST_MAX_RUN_MS, RST_DEBOUNCE_MS, RST_MIN_RUNS);
      play_gestures(250, 40);
      drain_results();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ased_pkg.sv
rtl/core/ased_mag_unit.sv
rtl/core/accel_shake_event_detector.sv
rtl/core/ased_checker.sv
sim/ased_shake_checker.sv
sim/tb_top.sv
